[sv/duplicated_secded_byte_codec_defines.svh]
// assertion macros used by the codec checker
`ifndef DUPLICATED_SECDED_BYTE_CODEC_DEFINES_SVH
`define DUPLICATED_SECDED_BYTE_CODEC_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DSBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define DSBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dsbc_pkg.sv]
`timescale 1ns / 1ps

package dsbc_pkg;

    localparam int NIB_W    = 4;
    localparam int BYTE_W   = 2 * NIB_W;
    localparam int STATUS_W = 2;

    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_CLEAN  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SINGLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNCORR = 2'd2;

    // syndrome patterns that point at a data bit
    localparam logic [NIB_W-1:0] SYN_D = 4'h7;
    localparam logic [NIB_W-1:0] SYN_C = 4'hB;
    localparam logic [NIB_W-1:0] SYN_B = 4'hD;
    localparam logic [NIB_W-1:0] SYN_A = 4'hE;

    typedef struct packed {
        logic [NIB_W-1:0]    nib;
        logic [STATUS_W-1:0] status;
    } check_t;

    // parities bcd, acd, abd, abc in bits 4 to 7
    function automatic logic [BYTE_W-1:0] make_word(input logic [NIB_W-1:0] nib);
        logic a, b, c, d;
        a = nib[3];
        b = nib[2];
        c = nib[1];
        d = nib[0];
        return {a ^ b ^ c, a ^ b ^ d, a ^ c ^ d, b ^ c ^ d, nib};
    endfunction

    function automatic check_t check_word(input logic [BYTE_W-1:0] w);
        logic [NIB_W-1:0] syn;
        check_t           r;
        syn[0] = w[0] ^ w[1] ^ w[2] ^ w[4];
        syn[1] = w[3] ^ w[1] ^ w[0] ^ w[5];
        syn[2] = w[3] ^ w[2] ^ w[0] ^ w[6];
        syn[3] = w[3] ^ w[2] ^ w[1] ^ w[7];
        r.nib    = w[NIB_W-1:0];
        r.status = ST_UNCORR;
        unique case (syn)
            4'h0:
            begin
                r.status = ST_CLEAN;
            end
            SYN_D:
            begin
                r.nib    = r.nib ^ 4'h1;
                r.status = ST_SINGLE;
            end
            SYN_C:
            begin
                r.nib    = r.nib ^ 4'h2;
                r.status = ST_SINGLE;
            end
            SYN_B:
            begin
                r.nib    = r.nib ^ 4'h4;
                r.status = ST_SINGLE;
            end
            SYN_A:
            begin
                r.nib    = r.nib ^ 4'h8;
                r.status = ST_SINGLE;
            end
            4'h1, 4'h2, 4'h4, 4'h8:
            begin
                // parity bit only, data stands
                r.status = ST_SINGLE;
            end
            default:
            begin
                r.status = ST_UNCORR;
            end
        endcase
        return r;
    endfunction

    // first copy unless it is beyond repair, then the duplicate as it decodes
    function automatic check_t decode_pair(input logic [BYTE_W-1:0] first,
                                           input logic [BYTE_W-1:0] dup);
        check_t p;
        check_t q;
        p = check_word(first);
        q = check_word(dup);
        if (p.status == ST_UNCORR)
        begin
            p.nib = q.nib;
        end
        return p;
    endfunction

endpackage

[sv/dsbc_if.sv]
`timescale 1ns / 1ps

interface dsbc_req_if
    import dsbc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] code_hi_a;
    logic [BYTE_W-1:0] code_hi_b;
    logic [BYTE_W-1:0] code_lo_a;
    logic [BYTE_W-1:0] code_lo_b;

    modport source (
        output valid, command, data_byte, code_hi_a, code_hi_b, code_lo_a, code_lo_b,
        input  ready
    );

    modport sink (
        input  valid, command, data_byte, code_hi_a, code_hi_b, code_lo_a, code_lo_b,
        output ready
    );
endinterface

interface dsbc_rsp_if
    import dsbc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_hi_a;
    logic [BYTE_W-1:0]   out_hi_b;
    logic [BYTE_W-1:0]   out_lo_a;
    logic [BYTE_W-1:0]   out_lo_b;
    logic [BYTE_W-1:0]   decoded_byte;
    logic [STATUS_W-1:0] hi_status;
    logic [STATUS_W-1:0] lo_status;
    logic                scrub_needed;

    modport source (
        output valid, out_hi_a, out_hi_b, out_lo_a, out_lo_b, decoded_byte,
               hi_status, lo_status, scrub_needed,
        input  ready
    );

    modport sink (
        input  valid, out_hi_a, out_hi_b, out_lo_a, out_lo_b, decoded_byte,
               hi_status, lo_status, scrub_needed,
        output ready
    );
endinterface

[sv/duplicated_secded_byte_codec.sv]
`timescale 1ns / 1ps
// an accepted word goes to the input register, its result to the result register on rsp
// throughput: one word per cycle unless rsp stalls, via the input and result registers
// both stages advance together whenever the result register is empty or being taken
// reset: asynchronous, clears both stage valid flags; payload registers are not reset
// no clearing pass, the block takes words from the first cycle after reset

module duplicated_secded_byte_codec
    import dsbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dsbc_req_if.sink   req,
    dsbc_rsp_if.source rsp
);

    logic              s1_valid_reg;
    logic              s1_cmd_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic [BYTE_W-1:0] s1_hi_a_reg;
    logic [BYTE_W-1:0] s1_hi_b_reg;
    logic [BYTE_W-1:0] s1_lo_a_reg;
    logic [BYTE_W-1:0] s1_lo_b_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_hi_reg;
    logic [BYTE_W-1:0]   out_lo_reg;
    logic [BYTE_W-1:0]   decoded_reg;
    logic [STATUS_W-1:0] hi_status_reg;
    logic [STATUS_W-1:0] lo_status_reg;
    logic                scrub_reg;

    logic                is_encode;
    logic [BYTE_W-1:0]   out_hi_word_next;
    logic [BYTE_W-1:0]   out_lo_word_next;
    logic [BYTE_W-1:0]   decoded_next;
    logic [STATUS_W-1:0] hi_status_next;
    logic [STATUS_W-1:0] lo_status_next;
    logic                scrub_next;
    check_t              hi_chk;
    check_t              lo_chk;

    logic adv_out;
    logic adv_in;

    assign adv_out   = !out_valid_reg || rsp.ready;
    assign adv_in    = !s1_valid_reg || adv_out;
    assign req.ready = adv_in;

    assign is_encode = (s1_cmd_reg == CMD_ENCODE);

    always_comb
    begin
        hi_chk = decode_pair(s1_hi_a_reg, s1_hi_b_reg);
        lo_chk = decode_pair(s1_lo_a_reg, s1_lo_b_reg);
        if (is_encode)
        begin
            out_hi_word_next = make_word(s1_data_reg[BYTE_W-1:NIB_W]);
            out_lo_word_next = make_word(s1_data_reg[NIB_W-1:0]);
            decoded_next     = '0;
            hi_status_next   = ST_CLEAN;
            lo_status_next   = ST_CLEAN;
            scrub_next       = 1'b0;
        end
        else
        begin
            out_hi_word_next = '0;
            out_lo_word_next = '0;
            decoded_next     = {hi_chk.nib, lo_chk.nib};
            hi_status_next   = hi_chk.status;
            lo_status_next   = lo_chk.status;
            scrub_next       = (hi_chk.status != ST_CLEAN) || (lo_chk.status != ST_CLEAN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_in)
            begin
                s1_valid_reg <= req.valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && req.valid)
        begin
            s1_cmd_reg  <= req.command;
            s1_data_reg <= req.data_byte;
            s1_hi_a_reg <= req.code_hi_a;
            s1_hi_b_reg <= req.code_hi_b;
            s1_lo_a_reg <= req.code_lo_a;
            s1_lo_b_reg <= req.code_lo_b;
        end
        if (adv_out && s1_valid_reg)
        begin
            out_hi_reg    <= out_hi_word_next;
            out_lo_reg    <= out_lo_word_next;
            decoded_reg   <= decoded_next;
            hi_status_reg <= hi_status_next;
            lo_status_reg <= lo_status_next;
            scrub_reg     <= scrub_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_hi_a     = out_hi_reg;
    assign rsp.out_hi_b     = out_hi_reg;
    assign rsp.out_lo_a     = out_lo_reg;
    assign rsp.out_lo_b     = out_lo_reg;
    assign rsp.decoded_byte = decoded_reg;
    assign rsp.hi_status    = hi_status_reg;
    assign rsp.lo_status    = lo_status_reg;
    assign rsp.scrub_needed = scrub_reg;

endmodule

[sv/dsbc_checker.sv]
`timescale 1ns / 1ps
`include "duplicated_secded_byte_codec_defines.svh"

module dsbc_checker
    import dsbc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [BYTE_W-1:0]   out_hi_a,
    input logic [BYTE_W-1:0]   out_hi_b,
    input logic [BYTE_W-1:0]   out_lo_a,
    input logic [BYTE_W-1:0]   out_lo_b,
    input logic [BYTE_W-1:0]   decoded_byte,
    input logic [STATUS_W-1:0] hi_status,
    input logic [STATUS_W-1:0] lo_status,
    input logic                scrub_needed
);

    // a stalled result word keeps its contents
    `DSBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(decoded_byte) && $stable(out_hi_a) && $stable(out_lo_a) && $stable(hi_status) && $stable(lo_status), "result word changed while stalled")

    // copies always match and every emitted word is a legal code word
    `DSBC_ASSERT_NOW(a_enc_words, rsp_valid, out_hi_a == out_hi_b && out_lo_a == out_lo_b && out_hi_a == make_word(out_hi_a[NIB_W-1:0]) && out_lo_a == make_word(out_lo_a[NIB_W-1:0]), "encoded words inconsistent")

    // scrub flag follows the two statuses, and no status code beyond uncorrectable
    `DSBC_ASSERT_NOW(a_scrub, rsp_valid, scrub_needed == (hi_status != ST_CLEAN || lo_status != ST_CLEAN) && hi_status <= ST_UNCORR && lo_status <= ST_UNCORR, "scrub flag or status inconsistent")

    // an error report only comes with a decode result, so no code words beside it
    `DSBC_ASSERT_NOW(a_mode_excl, rsp_valid && scrub_needed, out_hi_a == '0 && out_lo_a == '0, "error status with encoded words")

endmodule

bind duplicated_secded_byte_codec dsbc_checker u_dsbc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .out_hi_a     (rsp.out_hi_a),
    .out_hi_b     (rsp.out_hi_b),
    .out_lo_a     (rsp.out_lo_a),
    .out_lo_b     (rsp.out_lo_b),
    .decoded_byte (rsp.decoded_byte),
    .hi_status    (rsp.hi_status),
    .lo_status    (rsp.lo_status),
    .scrub_needed (rsp.scrub_needed)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dsbc_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] code_hi_a;
        logic [BYTE_W-1:0] code_hi_b;
        logic [BYTE_W-1:0] code_lo_a;
        logic [BYTE_W-1:0] code_lo_b;
    } codec_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_hi_a;
        logic [BYTE_W-1:0]   out_hi_b;
        logic [BYTE_W-1:0]   out_lo_a;
        logic [BYTE_W-1:0]   out_lo_b;
        logic [BYTE_W-1:0]   decoded_byte;
        logic [STATUS_W-1:0] hi_status;
        logic [STATUS_W-1:0] lo_status;
        logic                scrub_needed;
    } codec_result_t;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   fail_count;
    int   cycles;

    codec_result_t pending_results[$];

    dsbc_req_if req_if ();
    dsbc_rsp_if rsp_if ();

    duplicated_secded_byte_codec u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #4 clk = ~clk;

    // column of the parity matrix belonging to data bit i
    function automatic logic [NIB_W-1:0] parity_column(input int i);
        case (i)
            0: return SYN_D;
            1: return SYN_C;
            2: return SYN_B;
            default: return SYN_A;
        endcase
    endfunction

    function automatic logic [NIB_W-1:0] nibble_parity(input logic [NIB_W-1:0] nib);
        logic [NIB_W-1:0] p;
        p = '0;
        for (int i = 0; i < NIB_W; i++)
        begin
            if (nib[i])
            begin
                p = p ^ parity_column(i);
            end
        end
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] codeword(input logic [NIB_W-1:0] nib);
        return {nibble_parity(nib), nib};
    endfunction

    // odd syndrome weight is a single error, even nonzero weight is beyond repair
    function automatic logic [NIB_W+STATUS_W-1:0] repair_word(input logic [BYTE_W-1:0] w);
        logic [NIB_W-1:0]    syn;
        logic [NIB_W-1:0]    nib;
        logic [STATUS_W-1:0] status;
        syn = w[BYTE_W-1:NIB_W] ^ nibble_parity(w[NIB_W-1:0]);
        nib = w[NIB_W-1:0];
        if (syn == '0)
        begin
            status = ST_CLEAN;
        end
        else if ($countones(syn) % 2 == 1)
        begin
            status = ST_SINGLE;
            for (int i = 0; i < NIB_W; i++)
            begin
                if (syn == parity_column(i))
                begin
                    nib[i] = ~nib[i];
                end
            end
        end
        else
        begin
            status = ST_UNCORR;
        end
        return {nib, status};
    endfunction

    function automatic codec_result_t predict_codec(input codec_word_t w);
        codec_result_t               r;
        logic [NIB_W-1:0]            hi_nib;
        logic [NIB_W-1:0]            lo_nib;
        logic [STATUS_W-1:0]         hi_st;
        logic [STATUS_W-1:0]         lo_st;
        logic [NIB_W+STATUS_W-1:0]   dup_r;
        r = '0;
        if (w.command == CMD_ENCODE)
        begin
            r.out_hi_a = codeword(w.data_byte[BYTE_W-1:NIB_W]);
            r.out_hi_b = r.out_hi_a;
            r.out_lo_a = codeword(w.data_byte[NIB_W-1:0]);
            r.out_lo_b = r.out_lo_a;
        end
        else
        begin
            {hi_nib, hi_st} = repair_word(w.code_hi_a);
            {lo_nib, lo_st} = repair_word(w.code_lo_a);
            // duplicate taken as it decodes, its own status ignored
            if (hi_st == ST_UNCORR)
            begin
                dup_r  = repair_word(w.code_hi_b);
                hi_nib = dup_r[NIB_W+STATUS_W-1:STATUS_W];
            end
            if (lo_st == ST_UNCORR)
            begin
                dup_r  = repair_word(w.code_lo_b);
                lo_nib = dup_r[NIB_W+STATUS_W-1:STATUS_W];
            end
            r.decoded_byte = {hi_nib, lo_nib};
            r.hi_status    = hi_st;
            r.lo_status    = lo_st;
            r.scrub_needed = (hi_st != ST_CLEAN) || (lo_st != ST_CLEAN);
        end
        return r;
    endfunction

    // flip exactly n distinct bits of a code byte
    function automatic logic [BYTE_W-1:0] flip_bits(input logic [BYTE_W-1:0] w, input int n);
        logic [BYTE_W-1:0] mask;
        mask = '0;
        while ($countones(mask) < n)
        begin
            mask[$urandom_range(BYTE_W-1)] = 1'b1;
        end
        return w ^ mask;
    endfunction

    function automatic codec_word_t encode_word(input logic [BYTE_W-1:0] b);
        codec_word_t w;
        w.command   = CMD_ENCODE;
        w.data_byte = b;
        w.code_hi_a = BYTE_W'($urandom);
        w.code_hi_b = BYTE_W'($urandom);
        w.code_lo_a = BYTE_W'($urandom);
        w.code_lo_b = BYTE_W'($urandom);
        return w;
    endfunction

    function automatic codec_word_t decode_word(input logic [BYTE_W-1:0] hia,
                                                input logic [BYTE_W-1:0] hib,
                                                input logic [BYTE_W-1:0] loa,
                                                input logic [BYTE_W-1:0] lob);
        codec_word_t w;
        w.command   = CMD_DECODE;
        w.data_byte = BYTE_W'($urandom);
        w.code_hi_a = hia;
        w.code_hi_b = hib;
        w.code_lo_a = loa;
        w.code_lo_b = lob;
        return w;
    endfunction

    task automatic send_word(input codec_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.command   <= w.command;
        req_if.data_byte <= w.data_byte;
        req_if.code_hi_a <= w.code_hi_a;
        req_if.code_hi_b <= w.code_hi_b;
        req_if.code_lo_a <= w.code_lo_a;
        req_if.code_lo_b <= w.code_lo_b;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        pending_results = {pending_results, predict_codec(w)};
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_encode_edges();
        send_word(encode_word(8'h00));
        send_word(encode_word(8'hFF));
        send_word(encode_word(8'hA5));
        send_word(encode_word(8'h5A));
        send_word(encode_word(8'h0F));
        send_word(encode_word(8'hF0));
    endtask

    task automatic test_decode_repairs();
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] l;
        h = codeword(4'hC);
        l = codeword(4'h3);
        send_word(decode_word(h, h, l, l));
        send_word(decode_word(codeword(4'h0), codeword(4'h0), codeword(4'hF), codeword(4'hF)));
        // single data-bit error in each position
        for (int i = 0; i < NIB_W; i++)
        begin
            send_word(decode_word(h ^ (8'h1 << i), h, l ^ (8'h1 << i), l));
        end
        // parity-only error
        send_word(decode_word(h ^ 8'h10, h, l ^ 8'h80, l));
        // double error, clean duplicate
        send_word(decode_word(h ^ 8'h03, h, l ^ 8'h50, l));
        // all four parity bits flipped
        send_word(decode_word(h ^ 8'hF0, h, l ^ 8'hF0, l));
        // uncorrectable duplicate too
        send_word(decode_word(h ^ 8'h06, h ^ 8'h41, l ^ 8'h30, l ^ 8'hC0));
        // duplicate with a single error behind a bad first copy
        send_word(decode_word(h ^ 8'h81, h ^ 8'h04, l ^ 8'h22, l ^ 8'h20));
        send_word(decode_word(8'hFF, 8'hFF, 8'h00, 8'h00));
        send_word(decode_word(8'h00, 8'hFF, 8'hFF, 8'h00));
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        codec_word_t       w;
        logic [BYTE_W-1:0] h;
        logic [BYTE_W-1:0] l;
        int                pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                w = encode_word(BYTE_W'($urandom));
            end
            else if (pick < 45)
            begin
                w = decode_word(BYTE_W'($urandom), BYTE_W'($urandom),
                                BYTE_W'($urandom), BYTE_W'($urandom));
            end
            else
            begin
                h = codeword(NIB_W'($urandom));
                l = codeword(NIB_W'($urandom));
                w = decode_word(flip_bits(h, $urandom_range(4) % 4 == 0 ? 2 : $urandom_range(1)),
                                flip_bits(h, $urandom_range(9) < 7 ? 0 : $urandom_range(1, 3)),
                                flip_bits(l, $urandom_range(4)),
                                flip_bits(l, $urandom_range(9) < 7 ? 0 : $urandom_range(1, 3)));
            end
            send_word(w);
        end
    endtask

    // result side: random backpressure and the scoreboard
    always @(posedge clk)
    begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected word expected none actual %h", $time,
                         {rsp_if.out_hi_a, rsp_if.out_hi_b, rsp_if.out_lo_a, rsp_if.out_lo_b,
                          rsp_if.decoded_byte});
                fail_count++;
            end
            else
            begin
                codec_result_t want;
                want = pending_results.pop_front();
                check_field("out_hi_a", want.out_hi_a, rsp_if.out_hi_a);
                check_field("out_hi_b", want.out_hi_b, rsp_if.out_hi_b);
                check_field("out_lo_a", want.out_lo_a, rsp_if.out_lo_a);
                check_field("out_lo_b", want.out_lo_b, rsp_if.out_lo_b);
                check_field("decoded_byte", want.decoded_byte, rsp_if.decoded_byte);
                check_field("hi_status", BYTE_W'(want.hi_status), BYTE_W'(rsp_if.hi_status));
                check_field("lo_status", BYTE_W'(want.lo_status), BYTE_W'(rsp_if.lo_status));
                check_field("scrub_needed", BYTE_W'(want.scrub_needed),
                            BYTE_W'(rsp_if.scrub_needed));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cycles           = 0;
        fail_count       = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        rsp_if.ready     = 1'b0;
        req_if.valid     = 1'b0;
        req_if.command   = CMD_ENCODE;
        req_if.data_byte = '0;
        req_if.code_hi_a = '0;
        req_if.code_hi_b = '0;
        req_if.code_lo_a = '0;
        req_if.code_lo_b = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_edges();
        test_decode_repairs();
        wait_drained();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 85, 0);
        wait_drained();
        test_random_traffic(300, 0, 85);
        test_random_traffic(300, 22, 22);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
